>>> rtl/owsl_pkg.sv
// ----------------------------------------------------------------------------
// owsl_pkg
// Shared types and constants for the overwrite-oldest statistics log.
// ----------------------------------------------------------------------------
package owsl_pkg;

	// operation codes carried in the op field of a request
	typedef enum logic [1:0] {
		OP_LOG   = 2'd0,
		OP_DRAIN = 2'd1,
		OP_CLEAR = 2'd2
	} owsl_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} owsl_state_t;

	localparam logic [7:0] NOISE_MAX   = 8'hFF;
	localparam logic [6:0] MAX_RESULTS = 7'd64;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] noise_raw;
		logic [15:0] bin_zero;
		logic [15:0] bin_one;
		logic [15:0] bin_two;
		logic [15:0] bin_three;
		logic [6:0]  max_count;
	} owsl_req_t;

	typedef struct packed {
		logic        valid_res;
		logic        last;
		logic [7:0]  noise_level;
		logic [15:0] out_bin_zero;
		logic [15:0] out_bin_one;
		logic [15:0] out_bin_two;
		logic [15:0] out_bin_three;
	} owsl_rsp_t;

	// one read slot handed from the sequencer to the output stage
	typedef struct packed {
		logic go;    // a result enters the read stage this cycle
		logic data;  // result carries a stored entry (else an empty-drain result)
		logic last;  // final result of the drain
	} owsl_issue_t;

endpackage

>>> rtl/overwrite_oldest_stats_log_unit.sv
// ----------------------------------------------------------------------------
// overwrite_oldest_stats_log_unit
// Per-frame statistics ring log with overwrite of the oldest record.
// ----------------------------------------------------------------------------
// The log keeps up to DEPTH-1 frame records (saturated noise byte plus four
// 16-bit motion histogram bins) in two RAMs with registered reads. A log on
// a full ring drops the oldest record. A drain request emits min(max_count,
// 64, records held) results in order, one per cycle when rsp is not stalled,
// the final one flagged last; an empty ring or a zero max_count gives one
// result with valid_res low. The drain rate is set by the read address the
// two RAMs share, which the sequencer drives once per cycle while the output
// stage has room; a drain holds off the next request until its last read
// (or its empty result) is issued, and longer while results wait on
// rsp_stall. Results leave through a registered output, so the request side
// is freed as soon as the last read is issued.
// ----------------------------------------------------------------------------
module overwrite_oldest_stats_log_unit import owsl_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  owsl_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output owsl_rsp_t rsp
);

	localparam int PTR_W = $clog2(DEPTH);

	logic             wr_en, rd_en, adv;
	logic [PTR_W-1:0] wr_addr, rd_addr;
	logic [7:0]       wr_noise, rd_noise;
	logic [63:0]      wr_bins, rd_bins;
	owsl_issue_t      issue;

	// decode requests, move the pointers, sequence the drain reads
	owsl_ctrl #(
		.DEPTH (DEPTH),
		.PTR_W (PTR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.adv       (adv),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_noise  (wr_noise),
		.wr_bins   (wr_bins),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.issue     (issue)
	);

	// record storage: noise byte and packed bins, same address
	owsl_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH),
		.AW    (PTR_W)
	) u_noise_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_noise),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_noise)
	);

	owsl_ram #(
		.WIDTH (64),
		.DEPTH (DEPTH),
		.AW    (PTR_W)
	) u_bins_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_bins),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_bins)
	);

	// hold read data until the result register frees, then present it
	owsl_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.rd_noise  (rd_noise),
		.rd_bins   (rd_bins),
		.adv       (adv),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

>>> rtl/owsl_ram.sv
// ----------------------------------------------------------------------------
// owsl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module owsl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/owsl_ctrl.sv
// ----------------------------------------------------------------------------
// owsl_ctrl
// Ring pointers and drain sequencer: decodes requests, writes log entries,
// and issues one entry read per cycle while draining and the outq has room.
// ----------------------------------------------------------------------------
module owsl_ctrl import owsl_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int PTR_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  owsl_req_t        req,
	input  logic             adv,
	output logic             wr_en,
	output logic [PTR_W-1:0] wr_addr,
	output logic [7:0]       wr_noise,
	output logic [63:0]      wr_bins,
	output logic             rd_en,
	output logic [PTR_W-1:0] rd_addr,
	output owsl_issue_t      issue
);

	localparam int CMP_W = (PTR_W + 1 > 7) ? PTR_W + 1 : 7;

	owsl_state_t      state_q, state_d;
	logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
	logic [6:0]       cnt_q, cnt_d;
	logic             accept;
	logic [CMP_W-1:0] held, lim, take;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;

	// entries held, and how many this drain takes
	always_comb begin
		if (wp_q >= rp_q) begin
			held = CMP_W'(wp_q) - CMP_W'(rp_q);
		end else begin
			held = CMP_W'(wp_q) + CMP_W'(DEPTH) - CMP_W'(rp_q);
		end
		lim  = (req.max_count > MAX_RESULTS) ? CMP_W'(MAX_RESULTS) : CMP_W'(req.max_count);
		take = (held < lim) ? held : lim;
	end

	assign wr_addr  = wp_q;
	assign wr_noise = (req.noise_raw > 16'(NOISE_MAX)) ? NOISE_MAX : req.noise_raw[7:0];
	assign wr_bins  = {req.bin_three, req.bin_two, req.bin_one, req.bin_zero};
	assign rd_addr  = rp_q;
	assign rd_en    = issue.go && issue.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q    <= '0;
			rp_q    <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			rp_q    <= rp_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		wp_d    = wp_q;
		rp_d    = rp_q;
		cnt_d   = cnt_q;
		wr_en   = 1'b0;
		issue   = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.op)
						OP_LOG: begin
							wr_en = 1'b1;
							wp_d  = ptr_next(wp_q);
							// full ring: drop the oldest entry
							if (ptr_next(wp_q) == rp_q) begin
								rp_d = ptr_next(rp_q);
							end
						end
						OP_DRAIN: begin
							cnt_d   = take[6:0];
							state_d = ST_DRAIN;
						end
						OP_CLEAR: begin
							wp_d = '0;
							rp_d = '0;
						end
						default: ;
					endcase
				end
			end
			ST_DRAIN: begin
				if (adv) begin
					issue.go = 1'b1;
					if (cnt_q == '0) begin
						// nothing to drain: one empty result
						issue.last = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						issue.data = 1'b1;
						issue.last = (cnt_q == 7'd1);
						rp_d       = ptr_next(rp_q);
						cnt_d      = cnt_q - 7'd1;
						if (cnt_q == 7'd1) begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_log_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.op == OP_LOG |=> wp_q != rp_q)
		else $error("ring empty after a log");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_RESULTS)
		else $error("drain count above limit");

endmodule

>>> rtl/owsl_outq.sv
// ----------------------------------------------------------------------------
// owsl_outq
// Output stage: tracks the RAM read stage and the result register, and
// builds result transactions from read data or empty-drain tokens.
// ----------------------------------------------------------------------------
module owsl_outq import owsl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  owsl_issue_t issue,
	input  logic [7:0]  rd_noise,
	input  logic [63:0] rd_bins,
	output logic        adv,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output owsl_rsp_t   rsp
);

	logic      vld_s1, data_s1, last_s1;
	logic      rsp_vld_q;
	owsl_rsp_t rsp_q;
	logic      s1_move;

	assign s1_move   = vld_s1 && (!rsp_vld_q || !rsp_stall);
	assign adv       = !vld_s1 || s1_move;
	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			data_s1   <= 1'b0;
			last_s1   <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_s1  <= issue.go;
				data_s1 <= issue.data;
				last_s1 <= issue.last;
			end
			if (s1_move) begin
				rsp_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			rsp_q.valid_res     <= data_s1;
			rsp_q.last          <= last_s1;
			rsp_q.noise_level   <= data_s1 ? rd_noise : '0;
			rsp_q.out_bin_zero  <= data_s1 ? rd_bins[15:0] : '0;
			rsp_q.out_bin_one   <= data_s1 ? rd_bins[31:16] : '0;
			rsp_q.out_bin_two   <= data_s1 ? rd_bins[47:32] : '0;
			rsp_q.out_bin_three <= data_s1 ? rd_bins[63:48] : '0;
		end
	end

	a_issue_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		issue.go |-> adv)
		else $error("read issued into a full stage");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !data_s1 |-> last_s1)
		else $error("empty-drain result not marked last");

endmodule
